@@ rtl/asht_pkg.sv @@
// Shared types and constants for the address session hash table.
// Holds the command codes, key and session widths and the hash mixing constants.
// No dependencies.
package asht_pkg;

    localparam int KEY_W      = 48;
    localparam int IP_W       = 32;
    localparam int PORT_W     = 16;
    localparam int SESS_W     = 8;
    localparam int PORT_SHIFT = 16;
    localparam int MIX_SHIFT  = 33;

    localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic              used;
        logic [KEY_W-1:0]  key;
        logic [SESS_W-1:0] sess;
    } t_entry;

endpackage

@@ rtl/address_session_hash_table_top.sv @@
// Top level of the address session hash table: command sequencer and probe walk.
// Depends on asht_pkg, asht_hash and asht_ram.
//
// Usage:
// A command beat is taken at a rising edge where i_start is high and o_busy is
// low. It carries i_cmd (lookup, insert, clear), the client address and port,
// and the session number for an insert. Every command gives exactly one result
// beat: o_valid is high for one cycle with o_found, o_session_out and o_status.
// The receiver cannot stall; results must be taken when o_valid is high.
// Flow: lookup and insert run the hash unit (two 64-bit multiplies at four
// steps each on one 32x32 multiplier, then the done flag), plus a reciprocal
// reduction when MAP_SLOTS is not a power of two, then a RAM read state and a
// compare state for each probed slot, then the result is registered.
// A clear writes one slot per cycle over all MAP_SLOTS slots, then reports.
// An unused command code reports zeros in the next cycle without going busy.
// o_busy stays high for the whole command, so one command is in flight.
// After reset the block runs a clearing pass over all MAP_SLOTS slots of the
// slot RAM with o_busy high before it takes the first command.
module address_session_hash_table_top
    import asht_pkg::*;
#(
    parameter int MAP_SLOTS = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [1:0]        i_cmd,
    input  logic [IP_W-1:0]   i_ip_addr,
    input  logic [PORT_W-1:0] i_port_num,
    input  logic [SESS_W-1:0] i_session_index,
    output logic              o_valid,
    output logic              o_found,
    output logic [SESS_W-1:0] o_session_out,
    output logic              o_status
);

    localparam int AW = $clog2(MAP_SLOTS);
    localparam int ENTRY_W = $bits(t_entry);
    localparam logic [AW-1:0] LAST = AW'(MAP_SLOTS - 1);

    typedef enum logic [5:0] {
        S_INIT = 6'b000001,
        S_IDLE = 6'b000010,
        S_HASH = 6'b000100,
        S_RD   = 6'b001000,
        S_CHK  = 6'b010000,
        S_CLR  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmd;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [SESS_W-1:0] r_sess, n_sess;
    logic [AW-1:0]     r_addr, n_addr;
    logic [AW-1:0]     r_probe, n_probe;
    logic              r_valid, n_valid;
    logic              r_found, n_found;
    logic [SESS_W-1:0] r_sess_out, n_sess_out;
    logic              r_status, n_status;

    logic              accept;
    logic [KEY_W-1:0]  key_in;
    logic              hash_start;
    logic              hash_done;
    logic [AW-1:0]     hash_slot;
    logic              ram_we;
    t_entry            ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry            rd_entry;
    logic [AW-1:0]     addr_next;

    assign accept    = i_start && !o_busy;
    assign key_in    = ({{(KEY_W-IP_W){1'b0}}, i_ip_addr} << PORT_SHIFT)
                     ^ {{(KEY_W-PORT_W){1'b0}}, i_port_num};
    assign rd_entry  = t_entry'(ram_rdata);
    assign addr_next = (r_addr == LAST) ? '0 : r_addr + 1'b1;

    asht_hash #(
        .MAP_SLOTS (MAP_SLOTS)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_key   (key_in),
        .o_done  (hash_done),
        .o_slot  (hash_slot)
    );

    asht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAP_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_key      = r_key;
        n_sess     = r_sess;
        n_addr     = r_addr;
        n_probe    = r_probe;
        n_valid    = 1'b0;
        n_found    = 1'b0;
        n_sess_out = '0;
        n_status   = 1'b0;
        hash_start = 1'b0;
        ram_we     = 1'b0;
        ram_wdata  = '0;
        unique case (r_state)
            S_INIT, S_CLR: begin
                ram_we = 1'b1;
                if (r_addr == LAST) begin
                    n_addr  = '0;
                    n_valid = (r_state == S_CLR);
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd)
                        CMD_LOOKUP, CMD_INSERT: begin
                            n_cmd      = t_cmd'(i_cmd);
                            n_key      = key_in;
                            n_sess     = i_session_index;
                            hash_start = 1'b1;
                            n_state    = S_HASH;
                        end
                        CMD_CLEAR: begin
                            n_addr  = '0;
                            n_state = S_CLR;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    n_addr  = hash_slot;
                    n_probe = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                priority if (!rd_entry.used || rd_entry.key == r_key) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    if (r_cmd == CMD_INSERT) begin
                        ram_we         = 1'b1;
                        ram_wdata.used = 1'b1;
                        ram_wdata.key  = r_key;
                        ram_wdata.sess = r_sess;
                    end else begin
                        n_found    = rd_entry.used;
                        n_sess_out = rd_entry.used ? rd_entry.sess : '0;
                    end
                end else if (r_probe == LAST) begin
                    n_valid  = 1'b1;
                    n_status = (r_cmd == CMD_INSERT);
                    n_state  = S_IDLE;
                end else begin
                    n_addr  = addr_next;
                    n_probe = r_probe + 1'b1;
                    n_state = S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_addr  <= '0;
            r_probe <= '0;
            r_cmd   <= CMD_LOOKUP;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_probe <= n_probe;
            r_cmd   <= n_cmd;
            r_valid <= n_valid;
        end
        r_key      <= n_key;
        r_sess     <= n_sess;
        r_found    <= n_found;
        r_sess_out <= n_sess_out;
        r_status   <= n_status;
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_found       = r_found;
    assign o_session_out = r_sess_out;
    assign o_status      = r_status;

    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_busy)
        else $error("Block not busy during the clearing pass after reset.");

    a_hash_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd == CMD_LOOKUP || i_cmd == CMD_INSERT)) |=> o_busy)
        else $error("Lookup or insert accepted without going busy.");

    a_found_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_found |-> (o_valid && !o_status))
        else $error("Hit reported outside a valid result or with a full status.");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CHK || r_state == S_CLR || r_state == S_INIT))
        else $error("Slot RAM written outside the check or clear states.");

    a_insert_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK && r_cmd == CMD_INSERT) |=> !o_found)
        else $error("Insert reported a lookup hit.");

endmodule

@@ rtl/asht_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module asht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/asht_hash.sv @@
// Iterative murmur3 64-bit finalizer and home slot reduction.
// One 32x32 multiplier is reused for the partial products and the reduction; depends on asht_pkg.
module asht_hash
    import asht_pkg::*;
#(
    parameter int MAP_SLOTS = 512
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [KEY_W-1:0]             i_key,
    output logic                         o_done,
    output logic [$clog2(MAP_SLOTS)-1:0] o_slot
);

    localparam int AW = $clog2(MAP_SLOTS);
    localparam bit POW2 = ((MAP_SLOTS & (MAP_SLOTS - 1)) == 0);
    localparam logic [63:0] RECIP_W = ((64'd1 << (31 + AW)) + 64'(MAP_SLOTS) - 64'd1)
                                      / 64'(MAP_SLOTS);
    localparam logic [31:0] RECIP = RECIP_W[31:0];
    localparam logic [31:0] M_32  = 32'(MAP_SLOTS);

    typedef enum logic [6:0] {
        H_IDLE = 7'b0000001,
        H_P0   = 7'b0000010,
        H_P1   = 7'b0000100,
        H_P2   = 7'b0001000,
        H_P3   = 7'b0010000,
        H_MA   = 7'b0100000,
        H_MB   = 7'b1000000
    } t_hstate;

    t_hstate r_state, n_state;
    logic [63:0] r_v, n_v;
    logic [63:0] r_prod, n_prod;
    logic [63:0] r_acc, n_acc;
    logic        r_pass, n_pass;
    logic [1:0]  r_cnt, n_cnt;
    logic [15:0] r_rem, n_rem;
    logic [AW-1:0] r_slot, n_slot;
    logic        r_done, n_done;

    logic [63:0] key_ext;
    logic [63:0] mix_c;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_res;
    logic [31:0] hi_sum;
    logic [63:0] v_new, v_x;
    logic [31:0] mod_x;
    logic [63:0] quo_full;
    logic [31:0] mod_r;

    assign key_ext  = {{(64-KEY_W){1'b0}}, i_key};
    assign mix_c    = r_pass ? MIX_C2 : MIX_C1;
    assign mul_res  = {32'b0, mul_a} * {32'b0, mul_b};
    assign hi_sum   = r_acc[63:32] + r_prod[31:0];
    assign v_new    = {hi_sum, r_acc[31:0]};
    assign v_x      = v_new ^ (v_new >> MIX_SHIFT);
    assign mod_x    = {1'b0, r_rem, r_v[63:49]};
    assign quo_full = r_prod >> (31 + AW);
    assign mod_r    = mod_x - mul_res[31:0];

    always_comb begin
        mul_a = r_v[31:0];
        mul_b = mix_c[31:0];
        unique case (r_state)
            H_P1: begin
                mul_b = mix_c[63:32];
            end
            H_P2: begin
                mul_a = r_v[63:32];
            end
            H_MA: begin
                mul_a = mod_x;
                mul_b = RECIP;
            end
            H_MB: begin
                mul_a = quo_full[31:0];
                mul_b = M_32;
            end
            default: begin
                mul_a = r_v[31:0];
                mul_b = mix_c[31:0];
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_v     = r_v;
        n_prod  = r_prod;
        n_acc   = r_acc;
        n_pass  = r_pass;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_slot  = r_slot;
        n_done  = 1'b0;
        unique case (r_state)
            H_IDLE: begin
                if (i_start) begin
                    n_v     = key_ext ^ (key_ext >> MIX_SHIFT);
                    n_pass  = 1'b0;
                    n_state = H_P0;
                end
            end
            H_P0: begin
                n_prod  = mul_res;
                n_state = H_P1;
            end
            H_P1: begin
                n_acc   = r_prod;
                n_prod  = mul_res;
                n_state = H_P2;
            end
            H_P2: begin
                n_acc[63:32] = hi_sum;
                n_prod       = mul_res;
                n_state      = H_P3;
            end
            H_P3: begin
                n_v = v_x;
                if (!r_pass) begin
                    n_pass  = 1'b1;
                    n_state = H_P0;
                end else if (POW2) begin
                    n_slot  = v_x[AW-1:0];
                    n_done  = 1'b1;
                    n_state = H_IDLE;
                end else begin
                    n_rem   = {12'b0, v_x[63:60]};
                    n_v     = v_x << 4;
                    n_cnt   = '0;
                    n_state = H_MA;
                end
            end
            H_MA: begin
                n_prod  = mul_res;
                n_state = H_MB;
            end
            H_MB: begin
                n_rem = mod_r[15:0];
                n_v   = r_v << 15;
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    n_slot  = mod_r[AW-1:0];
                    n_done  = 1'b1;
                    n_state = H_IDLE;
                end else begin
                    n_state = H_MA;
                end
            end
            default: begin
                n_state = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
            r_pass  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_pass  <= n_pass;
            r_cnt   <= n_cnt;
        end
        r_v    <= n_v;
        r_prod <= n_prod;
        r_acc  <= n_acc;
        r_rem  <= n_rem;
        r_slot <= n_slot;
    end

    assign o_done = r_done;
    assign o_slot = r_slot;

endmodule
